### rtl/sma_pkg.sv
// Package for the stack machine arithmetic unit: opcodes, status codes,
// sequencer step codes, control word type and the microcode table.
// No dependencies.
package sma_pkg;

    // Word and stack sizing
    localparam int WORD_W          = 32;
    localparam int DEPTH_OUT_W     = 7;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int MIN_OPERANDS    = 2;
    localparam int DIV_CNT_W       = 6;

    // Operation codes
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SWAP = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Sequencer steps (microcode addresses)
    localparam logic [3:0] U_IDLE    = 4'd0;
    localparam logic [3:0] U_DECODE  = 4'd1;
    localparam logic [3:0] U_PUSH    = 4'd2;
    localparam logic [3:0] U_OPSEL   = 4'd3;
    localparam logic [3:0] U_ARITH   = 4'd4;
    localparam logic [3:0] U_SWAP    = 4'd5;
    localparam logic [3:0] U_DIVSTEP = 4'd6;
    localparam logic [3:0] U_DIVFIN  = 4'd7;
    localparam logic [3:0] U_DONE    = 4'd8;

    // Next-step selection
    localparam logic [2:0] SEQ_JUMP     = 3'd0;
    localparam logic [2:0] SEQ_WAIT_IN  = 3'd1;
    localparam logic [2:0] SEQ_DISP_DEC = 3'd2;
    localparam logic [2:0] SEQ_DISP_OP  = 3'd3;
    localparam logic [2:0] SEQ_LOOP_DIV = 3'd4;
    localparam logic [2:0] SEQ_WAIT_OUT = 3'd5;

    // Top-of-stack register source
    localparam logic [2:0] TOP_HOLD = 3'd0;
    localparam logic [2:0] TOP_PUSH = 3'd1;
    localparam logic [2:0] TOP_ALU  = 3'd2;
    localparam logic [2:0] TOP_MEM  = 3'd3;
    localparam logic [2:0] TOP_DIV  = 3'd4;

    // Entry count update
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    // Stack memory write address select
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_PUSH = 2'd1;
    localparam logic [1:0] WR_SWAP = 2'd2;

    typedef struct packed {
        logic [2:0] seq;
        logic [3:0] target;
        logic       in_rdy;
        logic       mem_rd;
        logic [1:0] wr_sel;
        logic [2:0] top_sel;
        logic [1:0] cnt_op;
        logic       div_load;
        logic       div_step;
        logic       stat_load;
        logic       out_load;
    } ucode_t;

    // Build one control word
    function automatic ucode_t uw(
        input logic [2:0] seq,
        input logic [3:0] target,
        input logic       in_rdy,
        input logic       mem_rd,
        input logic [1:0] wr_sel,
        input logic [2:0] top_sel,
        input logic [1:0] cnt_op,
        input logic       div_load,
        input logic       div_step,
        input logic       stat_load,
        input logic       out_load
    );
        ucode_t w;
        w.seq       = seq;
        w.target    = target;
        w.in_rdy    = in_rdy;
        w.mem_rd    = mem_rd;
        w.wr_sel    = wr_sel;
        w.top_sel   = top_sel;
        w.cnt_op    = cnt_op;
        w.div_load  = div_load;
        w.div_step  = div_step;
        w.stat_load = stat_load;
        w.out_load  = out_load;
        return w;
    endfunction

    // Microcode table, one control word per step
    function automatic ucode_t ucode_rom(input logic [3:0] step);
        ucode_t w;
        unique case (step)
            U_IDLE:    w = uw(SEQ_WAIT_IN,  U_DECODE,  1'b1, 1'b0, WR_NONE, TOP_HOLD,
                              CNT_HOLD, 1'b0, 1'b0, 1'b0, 1'b0);
            U_DECODE:  w = uw(SEQ_DISP_DEC, U_DONE,    1'b0, 1'b1, WR_NONE, TOP_HOLD,
                              CNT_HOLD, 1'b0, 1'b0, 1'b1, 1'b0);
            U_PUSH:    w = uw(SEQ_JUMP,     U_DONE,    1'b0, 1'b0, WR_PUSH, TOP_PUSH,
                              CNT_INC,  1'b0, 1'b0, 1'b0, 1'b0);
            U_OPSEL:   w = uw(SEQ_DISP_OP,  U_DONE,    1'b0, 1'b0, WR_NONE, TOP_HOLD,
                              CNT_HOLD, 1'b1, 1'b0, 1'b0, 1'b0);
            U_ARITH:   w = uw(SEQ_JUMP,     U_DONE,    1'b0, 1'b0, WR_NONE, TOP_ALU,
                              CNT_DEC,  1'b0, 1'b0, 1'b0, 1'b0);
            U_SWAP:    w = uw(SEQ_JUMP,     U_DONE,    1'b0, 1'b0, WR_SWAP, TOP_MEM,
                              CNT_HOLD, 1'b0, 1'b0, 1'b0, 1'b0);
            U_DIVSTEP: w = uw(SEQ_LOOP_DIV, U_DIVFIN,  1'b0, 1'b0, WR_NONE, TOP_HOLD,
                              CNT_HOLD, 1'b0, 1'b1, 1'b0, 1'b0);
            U_DIVFIN:  w = uw(SEQ_JUMP,     U_DONE,    1'b0, 1'b0, WR_NONE, TOP_DIV,
                              CNT_DEC,  1'b0, 1'b0, 1'b0, 1'b0);
            U_DONE:    w = uw(SEQ_WAIT_OUT, U_IDLE,    1'b0, 1'b0, WR_NONE, TOP_HOLD,
                              CNT_HOLD, 1'b0, 1'b0, 1'b0, 1'b1);
            default:   w = uw(SEQ_JUMP,     U_IDLE,    1'b0, 1'b0, WR_NONE, TOP_HOLD,
                              CNT_HOLD, 1'b0, 1'b0, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

### rtl/stack_machine_alu.sv
// Top level of the stack machine arithmetic unit: microcode sequencer,
// stack memory, add/sub datapath and a bit-serial divider.
// Depends on sma_pkg.
//
// The unit holds an operand stack of up to STACK_DEPTH signed 32-bit words
// and runs one operation per input item (push, add, swap, sub, div, nop;
// codes 5, 6 and 7 act as nop). Every item returns exactly one result item:
// the new top of stack (zero when empty), the depth and a status. Errors
// (short stack, divide by zero, push on a full stack) leave the stack
// untouched. One item is worked at a time: decode, then, unless an error
// or nop, a push step, or operand select and an add/sub, swap or restoring
// divide step (one quotient bit per cycle, then a finishing step), and last
// the final step. The top entry sits in a register and the rest in a
// one-port-write, one-port-read memory. A finished result waits in the
// output register while the next item is accepted; the unit holds in its
// final step only while a previous result is still stalled.
module stack_machine_alu
    import sma_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               req_type,
    input  logic signed [WORD_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] top_value,
    output logic [DEPTH_OUT_W-1:0]   stack_depth,
    output logic [1:0]               status
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    // Sequencer and control state
    logic [3:0]           upc_reg, upc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    ucode_t               uc;

    // Datapath registers
    logic [2:0]            op_reg;
    logic [WORD_W-1:0]     val_reg;
    logic [WORD_W-1:0]     top_reg, top_next;
    logic [WORD_W-1:0]     rd_data_reg;
    logic [1:0]            status_reg;
    logic [WORD_W-1:0]     rem_reg, rem_next;
    logic [WORD_W-1:0]     quo_reg, quo_next;
    logic [WORD_W-1:0]     dvs_reg;
    logic                  neg_reg;
    logic signed [WORD_W-1:0] top_value_reg;
    logic [DEPTH_OUT_W-1:0]   stack_depth_reg;
    logic [1:0]               status_out_reg;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

    logic                   in_take, out_free, out_load;
    logic                   is_push, is_bin, is_div;
    logic [1:0]             dec_status;
    logic [3:0]             dec_target, op_target;
    logic [CNT_W-1:0]       cnt_m1, cnt_m2;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [WORD_W-1:0]      alu_res, div_res;
    logic [WORD_W:0]        rem_sh, dvs_ext, rem_diff;
    logic                   rem_ge;
    logic [CNT_W+DEPTH_OUT_W-1:0] cnt_ext;

    // Fetch the control word of the current step
    assign uc       = ucode_rom(upc_reg);
    assign in_stall = !uc.in_rdy;
    assign in_take  = uc.in_rdy && in_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = uc.out_load && out_free;

    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign cnt_m2 = cnt_reg - CNT_W'(2);

    // Decode the latched opcode and check the stack
    always_comb
    begin
        is_push    = (op_reg == OP_PUSH);
        is_div     = (op_reg == OP_DIV);
        is_bin     = (op_reg == OP_ADD) || (op_reg == OP_SWAP) ||
                     (op_reg == OP_SUB) || is_div;
        dec_status = ST_OK;
        dec_target = U_DONE;
        if (is_push)
        begin
            if (cnt_reg >= CNT_W'(STACK_DEPTH))
                dec_status = ST_FULL;
            else
                dec_target = U_PUSH;
        end
        else if (is_bin)
        begin
            if (cnt_reg < CNT_W'(MIN_OPERANDS))
                dec_status = ST_SHORT;
            else if (is_div && (top_reg == '0))
                dec_status = ST_DIVZERO;
            else
                dec_target = U_OPSEL;
        end
    end

    // Dispatch on the operation once the second entry is read
    always_comb
    begin
        case (op_reg)
            OP_SWAP: op_target = U_SWAP;
            OP_DIV:  op_target = U_DIVSTEP;
            default: op_target = U_ARITH;
        endcase
    end

    // Select the next step
    always_comb
    begin
        unique case (uc.seq)
            SEQ_JUMP:     upc_next = uc.target;
            SEQ_WAIT_IN:  upc_next = in_take ? uc.target : upc_reg;
            SEQ_DISP_DEC: upc_next = dec_target;
            SEQ_DISP_OP:  upc_next = op_target;
            SEQ_LOOP_DIV: upc_next = (div_cnt_reg == DIV_CNT_W'(1)) ? uc.target : upc_reg;
            SEQ_WAIT_OUT: upc_next = out_free ? uc.target : upc_reg;
            default:      upc_next = U_IDLE;
        endcase
    end

    // Update the entry count
    always_comb
    begin
        case (uc.cnt_op)
            CNT_INC: cnt_next = cnt_reg + CNT_W'(1);
            CNT_DEC: cnt_next = cnt_m1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // Add or subtract: second entry op top
    assign alu_res = (op_reg == OP_SUB) ? (rd_data_reg - top_reg) : (rd_data_reg + top_reg);

    // One restoring divide step on magnitudes
    assign rem_sh   = {rem_reg, quo_reg[WORD_W-1]};
    assign dvs_ext  = {1'b0, dvs_reg};
    assign rem_ge   = (rem_sh >= dvs_ext);
    assign rem_diff = rem_sh - dvs_ext;
    assign div_res  = neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;

    always_comb
    begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        div_cnt_next = div_cnt_reg;
        if (uc.div_load)
        begin
            rem_next     = '0;
            quo_next     = rd_data_reg[WORD_W-1] ? (WORD_W'(0) - rd_data_reg) : rd_data_reg;
            div_cnt_next = DIV_CNT_W'(WORD_W);
        end
        else if (uc.div_step)
        begin
            rem_next     = rem_ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            quo_next     = {quo_reg[WORD_W-2:0], rem_ge};
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
        end
    end

    // Select the new top of stack
    always_comb
    begin
        case (uc.top_sel)
            TOP_PUSH: top_next = val_reg;
            TOP_ALU:  top_next = alu_res;
            TOP_MEM:  top_next = rd_data_reg;
            TOP_DIV:  top_next = div_res;
            default:  top_next = top_reg;
        endcase
    end

    // Spill the old top below the new one on push, or into the second slot on swap
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cnt_m1[AW-1:0];
        case (uc.wr_sel)
            WR_PUSH:
            begin
                mem_we = (cnt_reg != '0);
                mem_wa = cnt_m1[AW-1:0];
            end
            WR_SWAP:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_m2[AW-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Hold a result until it is taken
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign cnt_ext = {{DEPTH_OUT_W{1'b0}}, cnt_reg};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= U_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= req_type;
            val_reg <= push_value;
        end
        if (uc.stat_load)
            status_reg <= dec_status;
        if (uc.div_load)
        begin
            dvs_reg <= top_reg[WORD_W-1] ? (WORD_W'(0) - top_reg) : top_reg;
            neg_reg <= rd_data_reg[WORD_W-1] ^ top_reg[WORD_W-1];
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        top_reg <= top_next;
        if (out_load)
        begin
            top_value_reg   <= (cnt_reg == '0) ? '0 : top_reg;
            stack_depth_reg <= cnt_ext[DEPTH_OUT_W-1:0];
            status_out_reg  <= status_reg;
        end
    end

    // Stack memory below the top entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_wa] <= top_reg;
        if (uc.mem_rd)
            rd_data_reg <= stack_mem[cnt_m2[AW-1:0]];
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign stack_depth = stack_depth_reg;
    assign status      = status_out_reg;

    // Count never exceeds the stack size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count above stack size");

    // Count moves by at most one per cycle
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((cnt_reg == $past(cnt_reg)) ||
             (cnt_reg == $past(cnt_reg) + CNT_W'(1)) ||
             (cnt_reg == $past(cnt_reg) - CNT_W'(1))))
        else $error("entry count jumped");

    // Divider loop always has bits left
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == U_DIVSTEP) |-> (div_cnt_reg != '0))
        else $error("divider stepped with no bits left");

    // A loaded result is presented next cycle and the sequencer returns to idle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && (upc_reg == U_IDLE)))
        else $error("result load lost");

    // An accepted item enters decode; no new item is taken while an item is in progress
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (upc_reg == U_DECODE))
        else $error("accepted item did not enter decode");

endmodule
